// File: hdl/bqf_pkg.sv
// ----------------------------------------------------------------------------
// bqf_pkg - shared definitions for the biquad filter
// Widths, register indexes, control word layout and the microprogram ROM.
// ----------------------------------------------------------------------------
package bqf_pkg;

   localparam int SAMPLE_WIDTH_DEF = 24;
   localparam int COEF_WIDTH_DEF   = 24;
   localparam int DELAY_WIDTH      = 40;
   // low part of a delay operand fed to the multiplier in the first pass
   localparam int SPLIT_WIDTH      = 20;
   localparam int CSR_INDEX_WIDTH  = 3;
   localparam int PC_WIDTH         = 6;

   // reset coefficients as hundredths of one
   localparam longint RST_A1_PCT = 73;
   localparam longint RST_B1_PCT = 78;
   localparam longint RST_B2_PCT = 88;
   localparam longint PCT_SCALE  = 100;
   localparam longint PCT_HALF   = 50;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_TOPOLOGY,
      CSR_A0,
      CSR_A1,
      CSR_A2,
      CSR_B1,
      CSR_B2
   } csr_index_type;

   typedef enum logic [1:0] {
      TOPO_DF1,
      TOPO_DF2,
      TOPO_TDF1,
      TOPO_TDF2
   } topo_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_LO,
      MUL_HI
   } mul_type;

   typedef enum logic [2:0] {
      CF_A0,
      CF_A1,
      CF_A2,
      CF_B1,
      CF_B2
   } coef_type;

   typedef enum logic [2:0] {
      OP_X,
      OP_W,
      OP_Y,
      OP_FD1,
      OP_FD2,
      OP_BD1,
      OP_BD2
   } opnd_type;

   typedef enum logic [2:0] {
      AC_NONE,
      AC_SET_Q,
      AC_ADD_Q,
      AC_SUB_Q,
      AC_NEG_Q,
      AC_SET_SRC,
      AC_ADD_SRC
   } acc_type;

   typedef enum logic [2:0] {
      WB_NONE,
      WB_W,
      WB_Y,
      WB_FD1,
      WB_FD2,
      WB_BD1,
      WB_BD2
   } wb_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_DF1,
      SH_DF2
   } shift_type;

   typedef enum logic [1:0] {
      SQ_NEXT,
      SQ_DISPATCH,
      SQ_END
   } seq_type;

   typedef struct packed {
      mul_type   mul;
      coef_type  coef;
      opnd_type  opnd;
      logic      rnd;
      acc_type   acc;
      opnd_type  src;
      wb_type    wb;
      shift_type shift;
      seq_type   seq;
   } ctrl_type;

   localparam logic [PC_WIDTH-1:0] PC_DISPATCH = PC_WIDTH'(0);
   localparam logic [PC_WIDTH-1:0] PC_DF1      = PC_WIDTH'(1);
   localparam logic [PC_WIDTH-1:0] PC_DF2      = PC_WIDTH'(15);
   localparam logic [PC_WIDTH-1:0] PC_TDF1     = PC_WIDTH'(29);
   localparam logic [PC_WIDTH-1:0] PC_TDF2     = PC_WIDTH'(45);

   function automatic ctrl_type mk(input mul_type mul, input coef_type coef,
                                   input opnd_type opnd, input logic rnd,
                                   input acc_type acc, input opnd_type src,
                                   input wb_type wb, input shift_type shift,
                                   input seq_type seq);
      ctrl_type cw;
      cw.mul   = mul;
      cw.coef  = coef;
      cw.opnd  = opnd;
      cw.rnd   = rnd;
      cw.acc   = acc;
      cw.src   = src;
      cw.wb    = wb;
      cw.shift = shift;
      cw.seq   = seq;
      return cw;
   endfunction

   // Microprogram. A product takes LO then HI on the multiplier, is rounded
   // in the following step and then reaches the accumulator.
   function automatic ctrl_type ucode(input logic [PC_WIDTH-1:0] pc);
      ctrl_type cw;
      case (pc)
         // dispatch on topology
         6'd0:  cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_DISPATCH);
         // direct form I
         6'd1:  cw = mk(MUL_LO,   CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd2:  cw = mk(MUL_HI,   CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd3:  cw = mk(MUL_LO,   CF_A1, OP_FD1, 1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd4:  cw = mk(MUL_HI,   CF_A1, OP_FD1, 1'b0, AC_SET_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd5:  cw = mk(MUL_LO,   CF_A2, OP_FD2, 1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd6:  cw = mk(MUL_HI,   CF_A2, OP_FD2, 1'b0, AC_ADD_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd7:  cw = mk(MUL_LO,   CF_B1, OP_BD1, 1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd8:  cw = mk(MUL_HI,   CF_B1, OP_BD1, 1'b0, AC_ADD_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd9:  cw = mk(MUL_LO,   CF_B2, OP_BD2, 1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd10: cw = mk(MUL_HI,   CF_B2, OP_BD2, 1'b0, AC_SUB_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd11: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd12: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_SUB_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd13: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_Y,    SH_NONE, SQ_NEXT);
         6'd14: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_NONE, SH_DF1,  SQ_END);
         // direct form II (canonical)
         6'd15: cw = mk(MUL_LO,   CF_B1, OP_FD1, 1'b0, AC_SET_SRC, OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd16: cw = mk(MUL_HI,   CF_B1, OP_FD1, 1'b0, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd17: cw = mk(MUL_LO,   CF_B2, OP_FD2, 1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd18: cw = mk(MUL_HI,   CF_B2, OP_FD2, 1'b0, AC_SUB_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd19: cw = mk(MUL_LO,   CF_A1, OP_FD1, 1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd20: cw = mk(MUL_HI,   CF_A1, OP_FD1, 1'b0, AC_SUB_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd21: cw = mk(MUL_LO,   CF_A2, OP_FD2, 1'b1, AC_NONE,    OP_X,   WB_W,    SH_NONE, SQ_NEXT);
         6'd22: cw = mk(MUL_HI,   CF_A2, OP_FD2, 1'b0, AC_SET_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd23: cw = mk(MUL_LO,   CF_A0, OP_W,   1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd24: cw = mk(MUL_HI,   CF_A0, OP_W,   1'b0, AC_ADD_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd25: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd26: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_ADD_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd27: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_Y,    SH_NONE, SQ_NEXT);
         6'd28: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_NONE, SH_DF2,  SQ_END);
         // transposed direct form I
         6'd29: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_SET_SRC, OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd30: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_ADD_SRC, OP_BD1, WB_NONE, SH_NONE, SQ_NEXT);
         6'd31: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_W,    SH_NONE, SQ_NEXT);
         6'd32: cw = mk(MUL_LO,   CF_A0, OP_W,   1'b0, AC_SET_SRC, OP_FD1, WB_NONE, SH_NONE, SQ_NEXT);
         6'd33: cw = mk(MUL_HI,   CF_A0, OP_W,   1'b0, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd34: cw = mk(MUL_LO,   CF_B1, OP_W,   1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd35: cw = mk(MUL_HI,   CF_B1, OP_W,   1'b0, AC_ADD_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd36: cw = mk(MUL_LO,   CF_B2, OP_W,   1'b1, AC_SET_SRC, OP_BD2, WB_Y,    SH_NONE, SQ_NEXT);
         6'd37: cw = mk(MUL_HI,   CF_B2, OP_W,   1'b0, AC_SUB_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd38: cw = mk(MUL_LO,   CF_A1, OP_W,   1'b1, AC_NONE,    OP_X,   WB_BD1,  SH_NONE, SQ_NEXT);
         6'd39: cw = mk(MUL_HI,   CF_A1, OP_W,   1'b0, AC_NEG_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd40: cw = mk(MUL_LO,   CF_A2, OP_W,   1'b1, AC_SET_SRC, OP_FD2, WB_BD2,  SH_NONE, SQ_NEXT);
         6'd41: cw = mk(MUL_HI,   CF_A2, OP_W,   1'b0, AC_ADD_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd42: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b1, AC_NONE,    OP_X,   WB_FD1,  SH_NONE, SQ_NEXT);
         6'd43: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_SET_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd44: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_FD2,  SH_NONE, SQ_END);
         // transposed direct form II
         6'd45: cw = mk(MUL_LO,   CF_A0, OP_X,   1'b0, AC_SET_SRC, OP_FD1, WB_NONE, SH_NONE, SQ_NEXT);
         6'd46: cw = mk(MUL_HI,   CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd47: cw = mk(MUL_LO,   CF_A1, OP_X,   1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd48: cw = mk(MUL_HI,   CF_A1, OP_X,   1'b0, AC_ADD_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd49: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b1, AC_SET_SRC, OP_FD2, WB_Y,    SH_NONE, SQ_NEXT);
         6'd50: cw = mk(MUL_LO,   CF_B1, OP_Y,   1'b0, AC_ADD_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd51: cw = mk(MUL_HI,   CF_B1, OP_Y,   1'b0, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd52: cw = mk(MUL_LO,   CF_A2, OP_X,   1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd53: cw = mk(MUL_HI,   CF_A2, OP_X,   1'b0, AC_SUB_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd54: cw = mk(MUL_LO,   CF_B2, OP_Y,   1'b1, AC_NONE,    OP_X,   WB_FD1,  SH_NONE, SQ_NEXT);
         6'd55: cw = mk(MUL_HI,   CF_B2, OP_Y,   1'b0, AC_SET_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd56: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b1, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd57: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_SUB_Q,   OP_X,   WB_NONE, SH_NONE, SQ_NEXT);
         6'd58: cw = mk(MUL_NONE, CF_A0, OP_X,   1'b0, AC_NONE,    OP_X,   WB_FD2,  SH_NONE, SQ_END);
         default: cw = mk(MUL_NONE, CF_A0, OP_X, 1'b0, AC_NONE,    OP_X,   WB_NONE, SH_NONE, SQ_END);
      endcase
      return cw;
   endfunction

endpackage

// File: hdl/biquad_filter_four_topologies.sv
// ----------------------------------------------------------------------------
// biquad_filter_four_topologies - microcoded second-order IIR filter
// One sample in, one saturated sample out; direct I, direct II, transposed
// direct I or transposed direct II, picked by the topology register.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake              Payload
//  --------  ---  ---------------------  ------------------------------------
//  req       in   req_valid / req_ready  req_sample_in  (Q1.23, signed)
//  rsp       out  rsp_valid / rsp_ready  rsp_sample_out (Q1.23, saturated)
//  csr       in   csr_valid / csr_ready  csr_index, csr_data (always ready)
//
//  Processing: each sample runs one dispatch step and then the microprogram of
//  its topology, paced by the single multiplier that spends a low and a high
//  pass on each coefficient product. A new request is accepted only once the
//  previous program has finished.
//  Reset: synchronous; clears the delay line and loads the default coefficients.
//  Stalls: the final step of a transaction holds while the previous result
//  still waits on rsp; a waiting result does not block the next request.
// ----------------------------------------------------------------------------
module biquad_filter_four_topologies #(
   parameter int SAMPLE_WIDTH = bqf_pkg::SAMPLE_WIDTH_DEF,
   parameter int COEF_WIDTH   = bqf_pkg::COEF_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]       req_sample_in,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]       rsp_sample_out,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [bqf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [COEF_WIDTH-1:0]                csr_data
);

   localparam int DW    = bqf_pkg::DELAY_WIDTH;
   localparam int SPLIT = bqf_pkg::SPLIT_WIDTH;
   localparam int PCW   = bqf_pkg::PC_WIDTH;
   // fraction bits of a coefficient
   localparam int FRAC  = COEF_WIDTH - 2;
   // multiplier operand: one split half with sign
   localparam int OPW   = SPLIT + 1;
   localparam int MW    = COEF_WIDTH + OPW;
   // full exact product
   localparam int PW    = COEF_WIDTH + DW;
   localparam int RW    = PW + 1;
   // rounded product; never reaches the 48-bit limit
   localparam int QW    = RW - FRAC;
   // up to five products plus one delay value
   localparam int AW    = QW + 3;

   localparam longint COEF_ONE = longint'(1) << FRAC;
   localparam logic [COEF_WIDTH-1:0] RST_A0 = COEF_WIDTH'(COEF_ONE);
   localparam logic [COEF_WIDTH-1:0] RST_A1 = COEF_WIDTH'(
      (bqf_pkg::RST_A1_PCT * COEF_ONE + bqf_pkg::PCT_HALF) / bqf_pkg::PCT_SCALE);
   localparam logic [COEF_WIDTH-1:0] RST_A2 = COEF_WIDTH'(COEF_ONE);
   localparam logic [COEF_WIDTH-1:0] RST_B1 = COEF_WIDTH'(
      -((bqf_pkg::RST_B1_PCT * COEF_ONE + bqf_pkg::PCT_HALF) / bqf_pkg::PCT_SCALE));
   localparam logic [COEF_WIDTH-1:0] RST_B2 = COEF_WIDTH'(
      (bqf_pkg::RST_B2_PCT * COEF_ONE + bqf_pkg::PCT_HALF) / bqf_pkg::PCT_SCALE);

   localparam logic signed [RW-1:0] RND_HALF = RW'(1) << (FRAC - 1);
   localparam logic signed [AW-1:0] ACC_MAX  = AW'({1'b0, {(DW-1){1'b1}}});
   localparam logic signed [AW-1:0] ACC_MIN  = ~ACC_MAX;
   localparam logic signed [DW-1:0] OUT_MAX  = DW'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
   localparam logic signed [DW-1:0] OUT_MIN  = ~OUT_MAX;

   // sequencer
   logic                 busy_ff, busy_in;
   logic [PCW-1:0]       pc_ff, pc_in;
   bqf_pkg::ctrl_type    cw;
   logic                 step_go;
   logic                 step_end;
   logic                 req_fire;
   logic [PCW-1:0]       entry_pc;

   // configuration
   bqf_pkg::topo_type       topology_ff, topology_in;
   logic [COEF_WIDTH-1:0]   coef_a0_ff, coef_a0_in;
   logic [COEF_WIDTH-1:0]   coef_a1_ff, coef_a1_in;
   logic [COEF_WIDTH-1:0]   coef_a2_ff, coef_a2_in;
   logic [COEF_WIDTH-1:0]   coef_b1_ff, coef_b1_in;
   logic [COEF_WIDTH-1:0]   coef_b2_ff, coef_b2_in;

   // filter state and working registers
   logic signed [DW-1:0]    fd1_ff, fd1_in;
   logic signed [DW-1:0]    fd2_ff, fd2_in;
   logic signed [DW-1:0]    bd1_ff, bd1_in;
   logic signed [DW-1:0]    bd2_ff, bd2_in;
   logic signed [DW-1:0]    x_ff, x_in;
   logic signed [DW-1:0]    w_ff, w_in;
   logic signed [DW-1:0]    y_ff, y_in;
   logic signed [PW-1:0]    pp_ff, pp_in;
   logic signed [QW-1:0]    q_ff, q_in;
   logic signed [AW-1:0]    acc_ff, acc_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic signed [SAMPLE_WIDTH-1:0] rsp_sample_out_ff, rsp_sample_out_in;

   // datapath
   logic signed [COEF_WIDTH-1:0] coef_sel;
   logic signed [DW-1:0]         mul_v;
   logic signed [DW-1:0]         src_v;
   logic signed [OPW-1:0]        mul_b;
   logic signed [MW-1:0]         prod;
   logic signed [RW-1:0]         rnd_sum;
   logic signed [RW-1:0]         rnd_neg;
   logic signed [AW-1:0]         q_ext;
   logic signed [AW-1:0]         src_ext;
   logic signed [DW-1:0]         acc_sat;
   logic signed [SAMPLE_WIDTH-1:0] out_sat;

   assign cw        = bqf_pkg::ucode(pc_ff);
   assign req_ready = !busy_ff;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sample_out = rsp_sample_out_ff;

   // hold the last step until the result register is free
   assign step_end = (cw.seq == bqf_pkg::SQ_END);
   assign step_go  = busy_ff && !(step_end && rsp_valid_ff && !rsp_ready);

   // entry point of each topology's program
   always_comb begin
      case (topology_ff)
         bqf_pkg::TOPO_DF1:  entry_pc = bqf_pkg::PC_DF1;
         bqf_pkg::TOPO_DF2:  entry_pc = bqf_pkg::PC_DF2;
         bqf_pkg::TOPO_TDF1: entry_pc = bqf_pkg::PC_TDF1;
         bqf_pkg::TOPO_TDF2: entry_pc = bqf_pkg::PC_TDF2;
         default:            entry_pc = bqf_pkg::PC_DF1;
      endcase
   end

   // step counter: start at dispatch, advance, jump on topology, finish
   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         pc_in   = bqf_pkg::PC_DISPATCH;
      end else if (step_go) begin
         case (cw.seq)
            bqf_pkg::SQ_NEXT:     pc_in = pc_ff + PCW'(1);
            bqf_pkg::SQ_DISPATCH: pc_in = entry_pc;
            bqf_pkg::SQ_END:      busy_in = 1'b0;
            default:              busy_in = 1'b0;
         endcase
      end
   end

   // configuration writes; unknown indexes drop
   always_comb begin
      topology_in = topology_ff;
      coef_a0_in  = coef_a0_ff;
      coef_a1_in  = coef_a1_ff;
      coef_a2_in  = coef_a2_ff;
      coef_b1_in  = coef_b1_ff;
      coef_b2_in  = coef_b2_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bqf_pkg::CSR_TOPOLOGY: topology_in = bqf_pkg::topo_type'(csr_data[1:0]);
            bqf_pkg::CSR_A0:       coef_a0_in  = csr_data;
            bqf_pkg::CSR_A1:       coef_a1_in  = csr_data;
            bqf_pkg::CSR_A2:       coef_a2_in  = csr_data;
            bqf_pkg::CSR_B1:       coef_b1_in  = csr_data;
            bqf_pkg::CSR_B2:       coef_b2_in  = csr_data;
            default:               topology_in = topology_ff;
         endcase
      end
   end

   // operand selection
   always_comb begin
      case (cw.coef)
         bqf_pkg::CF_A0: coef_sel = coef_a0_ff;
         bqf_pkg::CF_A1: coef_sel = coef_a1_ff;
         bqf_pkg::CF_A2: coef_sel = coef_a2_ff;
         bqf_pkg::CF_B1: coef_sel = coef_b1_ff;
         bqf_pkg::CF_B2: coef_sel = coef_b2_ff;
         default:        coef_sel = coef_a0_ff;
      endcase
      case (cw.opnd)
         bqf_pkg::OP_X:   mul_v = x_ff;
         bqf_pkg::OP_W:   mul_v = w_ff;
         bqf_pkg::OP_Y:   mul_v = y_ff;
         bqf_pkg::OP_FD1: mul_v = fd1_ff;
         bqf_pkg::OP_FD2: mul_v = fd2_ff;
         bqf_pkg::OP_BD1: mul_v = bd1_ff;
         bqf_pkg::OP_BD2: mul_v = bd2_ff;
         default:         mul_v = x_ff;
      endcase
      case (cw.src)
         bqf_pkg::OP_X:   src_v = x_ff;
         bqf_pkg::OP_W:   src_v = w_ff;
         bqf_pkg::OP_Y:   src_v = y_ff;
         bqf_pkg::OP_FD1: src_v = fd1_ff;
         bqf_pkg::OP_FD2: src_v = fd2_ff;
         bqf_pkg::OP_BD1: src_v = bd1_ff;
         bqf_pkg::OP_BD2: src_v = bd2_ff;
         default:         src_v = x_ff;
      endcase
   end

   // split multiply: unsigned low half first, signed high half second
   always_comb begin
      if (cw.mul == bqf_pkg::MUL_LO) begin
         mul_b = $signed({1'b0, mul_v[SPLIT-1:0]});
      end else begin
         mul_b = OPW'($signed(mul_v[DW-1:SPLIT]));
      end
      prod = MW'(coef_sel) * MW'(mul_b);
   end

   // round half away from zero, then drop the fraction bits
   always_comb begin
      rnd_neg = RW'({1'b0, pp_ff[PW-1]});
      rnd_sum = RW'(pp_ff) + RND_HALF - rnd_neg;
      q_ext   = AW'(q_ff);
      src_ext = AW'(src_v);
   end

   // saturate accumulator to the delay width, y to the sample width
   always_comb begin
      if (acc_ff > ACC_MAX) begin
         acc_sat = DW'(ACC_MAX);
      end else if (acc_ff < ACC_MIN) begin
         acc_sat = DW'(ACC_MIN);
      end else begin
         acc_sat = DW'(acc_ff);
      end
      if (y_ff > OUT_MAX) begin
         out_sat = SAMPLE_WIDTH'(OUT_MAX);
      end else if (y_ff < OUT_MIN) begin
         out_sat = SAMPLE_WIDTH'(OUT_MIN);
      end else begin
         out_sat = SAMPLE_WIDTH'(y_ff);
      end
   end

   // datapath actions of the current control word
   always_comb begin
      x_in   = x_ff;
      w_in   = w_ff;
      y_in   = y_ff;
      fd1_in = fd1_ff;
      fd2_in = fd2_ff;
      bd1_in = bd1_ff;
      bd2_in = bd2_ff;
      pp_in  = pp_ff;
      q_in   = q_ff;
      acc_in = acc_ff;
      rsp_valid_in      = rsp_valid_ff;
      rsp_sample_out_in = rsp_sample_out_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (req_fire) begin
         x_in = DW'(req_sample_in);
      end

      if (step_go) begin
         case (cw.mul)
            bqf_pkg::MUL_LO: pp_in = PW'(prod);
            bqf_pkg::MUL_HI: pp_in = pp_ff + (PW'(prod) <<< SPLIT);
            default:         pp_in = pp_ff;
         endcase

         if (cw.rnd) begin
            q_in = QW'(rnd_sum >>> FRAC);
         end

         case (cw.acc)
            bqf_pkg::AC_SET_Q:   acc_in = q_ext;
            bqf_pkg::AC_ADD_Q:   acc_in = acc_ff + q_ext;
            bqf_pkg::AC_SUB_Q:   acc_in = acc_ff - q_ext;
            bqf_pkg::AC_NEG_Q:   acc_in = -q_ext;
            bqf_pkg::AC_SET_SRC: acc_in = src_ext;
            bqf_pkg::AC_ADD_SRC: acc_in = acc_ff + src_ext;
            default:             acc_in = acc_ff;
         endcase

         case (cw.wb)
            bqf_pkg::WB_W:   w_in   = acc_sat;
            bqf_pkg::WB_Y:   y_in   = acc_sat;
            bqf_pkg::WB_FD1: fd1_in = acc_sat;
            bqf_pkg::WB_FD2: fd2_in = acc_sat;
            bqf_pkg::WB_BD1: bd1_in = acc_sat;
            bqf_pkg::WB_BD2: bd2_in = acc_sat;
            default:         w_in   = w_ff;
         endcase

         // advance the delay lines of the direct forms
         case (cw.shift)
            bqf_pkg::SH_DF1: begin
               fd2_in = fd1_ff;
               fd1_in = x_ff;
               bd2_in = bd1_ff;
               bd1_in = y_ff;
            end
            bqf_pkg::SH_DF2: begin
               fd2_in = fd1_ff;
               fd1_in = w_ff;
            end
            default: begin
               fd2_in = fd2_in;
            end
         endcase

         // publish the result
         if (step_end) begin
            rsp_valid_in      = 1'b1;
            rsp_sample_out_in = out_sat;
         end
      end
   end

   // control and filter state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= bqf_pkg::PC_DISPATCH;
         rsp_valid_ff <= 1'b0;
         topology_ff  <= bqf_pkg::TOPO_DF1;
         coef_a0_ff   <= RST_A0;
         coef_a1_ff   <= RST_A1;
         coef_a2_ff   <= RST_A2;
         coef_b1_ff   <= RST_B1;
         coef_b2_ff   <= RST_B2;
         fd1_ff       <= '0;
         fd2_ff       <= '0;
         bd1_ff       <= '0;
         bd2_ff       <= '0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         topology_ff  <= topology_in;
         coef_a0_ff   <= coef_a0_in;
         coef_a1_ff   <= coef_a1_in;
         coef_a2_ff   <= coef_a2_in;
         coef_b1_ff   <= coef_b1_in;
         coef_b2_ff   <= coef_b2_in;
         fd1_ff       <= fd1_in;
         fd2_ff       <= fd2_in;
         bd1_ff       <= bd1_in;
         bd2_ff       <= bd2_in;
      end
   end

   // working registers and result payload
   always_ff @(posedge clock) begin
      x_ff              <= x_in;
      w_ff              <= w_in;
      y_ff              <= y_in;
      pp_ff             <= pp_in;
      q_ff              <= q_in;
      acc_ff            <= acc_in;
      rsp_sample_out_ff <= rsp_sample_out_in;
   end

endmodule
